// ===== design/bhm_pkg.sv =====
// ----------------------------------------------------------------------------
// bhm_pkg: shared types and constants of the backend health monitor
// Event codes, lazy states, mode codes, register indexes and the control
// structures passed between the core and its window and scheduler units.
// ----------------------------------------------------------------------------
package bhm_pkg;

	localparam int WINDOW_DEF = 128;

	localparam int TIME_W    = 32;
	localparam int RUN_W     = 16;
	localparam int DELAY_W   = 24;
	localparam int EXP_LIMIT = 24;
	localparam int SHIFT_W   = 16 + EXP_LIMIT - 1;
	localparam int CFG_W     = 24;
	localparam int PCT_SCALE = 100;

	typedef enum logic [1:0] {
		ACT_POLL     = 2'd0,
		ACT_RESULT   = 2'd1,
		ACT_RESPONSE = 2'd2,
		ACT_TIMEOUT  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		LZ_HEALTHY   = 2'd0,
		LZ_POTENTIAL = 2'd1,
		LZ_FAILED    = 2'd2
	} lazy_t;

	localparam logic [2:0] MODE_AUTO        = 3'd0;
	localparam logic [2:0] MODE_LAZY_TO_LIN = 3'd1;
	localparam logic [2:0] MODE_LAZY_TO_EXP = 3'd2;
	localparam logic [2:0] MODE_LAZY_SF_LIN = 3'd3;
	localparam logic [2:0] MODE_LAZY_SF_EXP = 3'd4;

	localparam logic [2:0] REG_MODE            = 3'd0;
	localparam logic [2:0] REG_CHECK_INTERVAL  = 3'd1;
	localparam logic [2:0] REG_RISE_COUNT      = 3'd2;
	localparam logic [2:0] REG_FALL_COUNT      = 3'd3;
	localparam logic [2:0] REG_MIN_SAMPLES     = 3'd4;
	localparam logic [2:0] REG_FAIL_PERCENT    = 3'd5;
	localparam logic [2:0] REG_FAILED_INTERVAL = 3'd6;
	localparam logic [2:0] REG_MAX_BACKOFF     = 3'd7;

	localparam logic [3:0] RCODE_SERVFAIL = 4'd2;

	// window update for one transaction
	typedef struct packed {
		logic push;
		logic fail;
		logic clear;
	} win_ctrl_t;

	// inputs of one next-check computation
	typedef struct packed {
		logic              exp_mode;
		lazy_t             status;
		logic              success_nz;
		logic [RUN_W-1:0]  fail_run;
		logic              scheduled;
		logic [TIME_W-1:0] now;
	} sched_req_t;

	function automatic logic [RUN_W-1:0] sat_inc16(input logic [RUN_W-1:0] v);
		sat_inc16 = (&v) ? v : v + RUN_W'(1);
	endfunction

endpackage

// ===== design/backend_health_monitor_core.sv =====
// ----------------------------------------------------------------------------
// backend_health_monitor_core: health tracking for one back-end server
// Event-driven up/down status, lazy failure detection and check scheduling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one event transaction: a poll,
//   a check result, a query response or a timeout. Output channel
//   (out_valid/out_stall) returns exactly one result transaction per event:
//   send_check, is_up, lazy_state and next_check_time after the event.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data
//   while no event is in flight.
//   Results are registered: an accepted event is held in the input register,
//   then its outcome in the result register, which out_valid presents.
//   Throughput: one event per cycle while out_stall does not hold a result;
//   all state is updated in the cycle the event leaves the input register,
//   the window memory keeps its oldest entry prefetched, so there is no
//   dependency stall.
//   Reset: all status and counters return to their initial values at once;
//   the outcome memory needs no clearing pass, running counts tell which
//   entries are live.
//   Stall: while out_stall holds a waiting result, one more event is taken
//   into the input register; in_stall then rises until the result drains.
// ----------------------------------------------------------------------------
module backend_health_monitor_core
	import bhm_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	// event channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          action,
	input  logic [TIME_W-1:0]   now,
	input  logic                check_ok,
	input  logic                initial_req,
	input  logic [3:0]          rcode,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic                send_check,
	output logic                is_up,
	output logic [1:0]          lazy_state,
	output logic [TIME_W-1:0]   next_check_time
);

	// configuration registers
	logic [2:0]         mode_q;
	logic [15:0]        check_interval_q;
	logic [7:0]         rise_count_q;
	logic [7:0]         fall_count_q;
	logic [7:0]         min_samples_q;
	logic [6:0]         fail_percent_q;
	logic [15:0]        failed_interval_q;
	logic [DELAY_W-1:0] max_backoff_q;

	// input register
	logic              valid_s1;
	action_t           action_s1;
	logic [TIME_W-1:0] now_s1;
	logic              check_ok_s1;
	logic              initial_req_s1;
	logic [3:0]        rcode_s1;

	// result register
	logic              valid_s2;
	logic              send_check_s2;
	logic              is_up_s2;
	lazy_t             lazy_state_s2;
	logic [TIME_W-1:0] next_check_time_s2;

	// server state
	logic              up_q, up_d;
	lazy_t             status_q, status_d;
	logic [RUN_W-1:0]  fail_run_q, fail_run_d;
	logic [RUN_W-1:0]  success_run_q, success_run_d;
	logic [15:0]       countdown_q, countdown_d;
	logic [TIME_W-1:0] next_check_q;

	logic              out_free, fire, accept;
	logic              is_lazy, is_exp, counts_sf;
	logic              send;
	logic              sched_en, sched_scheduled;
	logic              next_up;
	logic              win_push, win_fail, win_clear;
	logic              trigger;
	logic [RUN_W-1:0]  fail_inc, success_inc;
	logic [TIME_W-1:0] sched_time;
	win_ctrl_t         win_ctrl;
	sched_req_t        sched_req;

	// ------------------------------------------------------------------
	// configuration writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q            <= MODE_AUTO;
			check_interval_q  <= 16'd1;
			rise_count_q      <= 8'd1;
			fall_count_q      <= 8'd1;
			min_samples_q     <= 8'd1;
			fail_percent_q    <= 7'd20;
			failed_interval_q <= 16'd30;
			max_backoff_q     <= DELAY_W'(3600);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:            mode_q            <= cfg_data[2:0];
				REG_CHECK_INTERVAL:  check_interval_q  <= cfg_data[15:0];
				REG_RISE_COUNT:      rise_count_q      <= cfg_data[7:0];
				REG_FALL_COUNT:      fall_count_q      <= cfg_data[7:0];
				REG_MIN_SAMPLES:     min_samples_q     <= cfg_data[7:0];
				REG_FAIL_PERCENT:    fail_percent_q    <= cfg_data[6:0];
				REG_FAILED_INTERVAL: failed_interval_q <= cfg_data[15:0];
				REG_MAX_BACKOFF:     max_backoff_q     <= cfg_data[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// modes above the lazy range behave as auto
	assign is_lazy   = (mode_q >= MODE_LAZY_TO_LIN) && (mode_q <= MODE_LAZY_SF_EXP);
	assign is_exp    = (mode_q == MODE_LAZY_TO_EXP) || (mode_q == MODE_LAZY_SF_EXP);
	assign counts_sf = (mode_q == MODE_LAZY_SF_LIN) || (mode_q == MODE_LAZY_SF_EXP);

	// ------------------------------------------------------------------
	// handshake: the result register frees up when empty or being taken
	// ------------------------------------------------------------------
	assign out_free = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload holds while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1      <= action_t'(action);
			now_s1         <= now;
			check_ok_s1    <= check_ok;
			initial_req_s1 <= initial_req;
			rcode_s1       <= rcode;
		end
	end

	// ------------------------------------------------------------------
	// event decode and next state
	// ------------------------------------------------------------------
	assign fail_inc    = sat_inc16(fail_run_q);
	assign success_inc = sat_inc16(success_run_q);

	always_comb begin
		up_d            = up_q;
		status_d        = status_q;
		fail_run_d      = fail_run_q;
		success_run_d   = success_run_q;
		countdown_d     = countdown_q;
		send            = 1'b0;
		sched_en        = 1'b0;
		sched_scheduled = 1'b0;
		next_up         = up_q;
		win_push        = 1'b0;
		win_fail        = 1'b0;
		win_clear       = 1'b0;
		unique case (action_s1)
			ACT_POLL: begin
				if (is_lazy) begin
					case (status_q)
						LZ_POTENTIAL: send = 1'b1;
						LZ_FAILED: begin
							if (next_check_q <= now_s1) begin
								sched_en        = 1'b1;
								sched_scheduled = 1'b1;
								send            = 1'b1;
							end
						end
						default: begin
							// judge the window failure rate
							if (trigger) begin
								win_clear       = 1'b1;
								status_d        = LZ_POTENTIAL;
								sched_en        = 1'b1;
								sched_scheduled = 1'b1;
								send            = 1'b1;
							end
						end
					endcase
				end else if (countdown_q > 16'd1) begin
					countdown_d = countdown_q - 16'd1;
				end else begin
					countdown_d = check_interval_q;
					send        = 1'b1;
				end
			end
			ACT_RESULT: begin
				if (initial_req_s1) begin
					// start-up check bypasses hysteresis
					up_d = check_ok_s1;
					if (!check_ok_s1) begin
						fail_run_d = fail_inc;
						status_d   = LZ_FAILED;
						sched_en   = 1'b1;
					end
				end else if (check_ok_s1) begin
					next_up    = 1'b1;
					fail_run_d = '0;
					if (!up_q) begin
						success_run_d = success_inc;
						if (success_inc < RUN_W'(rise_count_q)) begin
							next_up  = 1'b0;
							sched_en = is_lazy;
						end
					end
					if (next_up && is_lazy) begin
						status_d  = LZ_HEALTHY;
						win_clear = 1'b1;
					end
					up_d = next_up;
				end else begin
					next_up       = 1'b0;
					success_run_d = '0;
					fail_run_d    = fail_inc;
					if (up_q) begin
						if (fail_inc < RUN_W'(fall_count_q)) begin
							next_up = 1'b1;
						end else if (is_lazy) begin
							status_d   = LZ_FAILED;
							fail_run_d = '0;
							sched_en   = 1'b1;
						end
					end
					up_d = next_up;
				end
			end
			ACT_RESPONSE: begin
				win_push = is_lazy;
				win_fail = counts_sf && (rcode_s1 == RCODE_SERVFAIL);
			end
			ACT_TIMEOUT: begin
				win_push = is_lazy;
				win_fail = 1'b1;
			end
			default: ;
		endcase
	end

	// window only moves when the transaction leaves the input register
	assign win_ctrl.push  = win_push && fire;
	assign win_ctrl.fail  = win_fail;
	assign win_ctrl.clear = win_clear && fire;

	bhm_window #(
		.WINDOW(WINDOW)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (win_ctrl),
		.min_samples  (min_samples_q),
		.fail_percent (fail_percent_q),
		.trigger      (trigger)
	);

	// scheduler sees the state as it stands after this event
	assign sched_req.exp_mode   = is_exp;
	assign sched_req.status     = status_d;
	assign sched_req.success_nz = (success_run_d != '0);
	assign sched_req.fail_run   = fail_run_d;
	assign sched_req.scheduled  = sched_scheduled;
	assign sched_req.now        = now_s1;

	bhm_sched u_sched (
		.req             (sched_req),
		.check_interval  (check_interval_q),
		.failed_interval (failed_interval_q),
		.max_backoff     (max_backoff_q),
		.next_time       (sched_time)
	);

	// ------------------------------------------------------------------
	// commit state on fire
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q          <= 1'b1;
			status_q      <= LZ_HEALTHY;
			fail_run_q    <= '0;
			success_run_q <= '0;
			countdown_q   <= '0;
			next_check_q  <= '0;
		end else if (fire) begin
			up_q          <= up_d;
			status_q      <= status_d;
			fail_run_q    <= fail_run_d;
			success_run_q <= success_run_d;
			countdown_q   <= countdown_d;
			if (sched_en)
				next_check_q <= sched_time;
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			send_check_s2      <= send;
			is_up_s2           <= up_d;
			lazy_state_s2      <= status_d;
			next_check_time_s2 <= sched_en ? sched_time : next_check_q;
		end
	end

	assign out_valid       = valid_s2;
	assign send_check      = send_check_s2;
	assign is_up           = is_up_s2;
	assign lazy_state      = lazy_state_s2;
	assign next_check_time = next_check_time_s2;

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with nothing to hold");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_stall && !fire |=> !valid_s2)
		else $error("taken result still presented");
	a_send_only_poll: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (action_s1 != ACT_POLL) |=> !send_check_s2)
		else $error("check requested by a non-poll event");
	a_sched_commit: assert property (@(posedge clk) disable iff (!arst_n)
		fire && sched_en |=> next_check_q == next_check_time_s2)
		else $error("result time differs from scheduled time");
`endif

endmodule

// ===== design/bhm_window.sv =====
// ----------------------------------------------------------------------------
// bhm_window: circular window of recent query outcomes
// Keeps running sample and failure counts over a one-bit outcome memory and
// flags when the failure rate reaches the configured threshold over at least min_samples samples.
// ----------------------------------------------------------------------------
module bhm_window
	import bhm_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  win_ctrl_t ctrl,
	input  logic [7:0] min_samples,
	input  logic [6:0] fail_percent,
	output logic      trigger
);

	localparam int HW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW = $clog2(WINDOW + 1);
	localparam int JW = (CW > 8) ? CW : 8;
	localparam int PW = CW + 7;

	logic          mem [WINDOW];
	logic          oldest_q;
	logic [HW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] fails_q, fails_d;
	logic          full;
	logic [PW-1:0] fail_scaled, thresh;

	assign full = (count_q == CW'(WINDOW));

	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		fails_d = fails_q;
		if (ctrl.clear) begin
			count_d = '0;
			fails_d = '0;
		end else if (ctrl.push) begin
			if (full) begin
				if (oldest_q && (fails_q != '0))
					fails_d = fails_q - CW'(1);
			end else begin
				count_d = count_q + CW'(1);
			end
			if (ctrl.fail)
				fails_d = fails_d + CW'(1);
			head_d = (head_q == HW'(WINDOW - 1)) ? '0 : head_q + HW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			fails_q <= '0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
			fails_q <= fails_d;
		end
	end

	// keep the entry at the next head prefetched so the oldest bit is ready
	always_ff @(posedge clk) begin
		if (ctrl.push && !ctrl.clear)
			mem[head_q] <= ctrl.fail;
		if (ctrl.push && !ctrl.clear && (head_q == head_d))
			oldest_q <= ctrl.fail;
		else
			oldest_q <= mem[head_d];
	end

	assign fail_scaled = PW'(fails_q) * PW'(PCT_SCALE);
	assign thresh      = PW'(fail_percent) * PW'(count_q);
	assign trigger     = (JW'(count_q) >= JW'(min_samples)) && (count_q != '0) &&
	                     (fail_scaled >= thresh);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(WINDOW))
		else $error("window count above depth");
	a_fails_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fails_q <= count_q)
		else $error("window failures above sample count");
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clear |=> (count_q == '0) && (fails_q == '0))
		else $error("window not empty after clear");
`endif

endmodule

// ===== design/bhm_sched.sv =====
// ----------------------------------------------------------------------------
// bhm_sched: next lazy check time
// Picks a fixed, recheck or exponential backoff delay, limits it and adds it
// to the current time with saturation.
// ----------------------------------------------------------------------------
module bhm_sched
	import bhm_pkg::*;
(
	input  sched_req_t          req,
	input  logic [15:0]         check_interval,
	input  logic [15:0]         failed_interval,
	input  logic [DELAY_W-1:0]  max_backoff,
	output logic [TIME_W-1:0]   next_time
);

	logic [RUN_W-1:0]   n;
	logic [SHIFT_W-1:0] shifted;
	logic [DELAY_W-1:0] delay;
	logic [TIME_W:0]    sum;

	assign n       = req.fail_run + RUN_W'(req.scheduled);
	assign shifted = SHIFT_W'(failed_interval) << n[4:0];

	always_comb begin
		if (!req.exp_mode)
			delay = DELAY_W'(failed_interval);
		else if (req.status == LZ_POTENTIAL)
			delay = DELAY_W'(check_interval);
		else if (req.success_nz)
			delay = DELAY_W'(failed_interval);
		else if (failed_interval == '0)
			delay = '0;
		else if (n >= RUN_W'(EXP_LIMIT))
			delay = max_backoff;
		else if (shifted > SHIFT_W'(max_backoff))
			delay = max_backoff;
		else
			delay = shifted[DELAY_W-1:0];
	end

	assign sum       = (TIME_W + 1)'(req.now) + (TIME_W + 1)'(delay);
	assign next_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

endmodule
